@@ rtl/core/pll_divider_search_encode_core_macros.svh @@
// Assertion macros used by the checker file of the PLL divider search core.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef PLL_DIVIDER_SEARCH_ENCODE_CORE_MACROS_SVH
`define PLL_DIVIDER_SEARCH_ENCODE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDSE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pdse_pkg.sv @@
`default_nettype none

package pdse_pkg;

    // search bounds
    localparam int MAX_MULT   = 60;
    localparam int MAX_PREDIV = 255;

    // field widths
    localparam int FIN_W   = 26;
    localparam int VCO_W   = 32;
    localparam int TGT_W   = 28;
    localparam int M_W     = 6;
    localparam int N_W     = 8;
    localparam int MDEC_W  = 17;
    localparam int NDEC_W  = 10;
    localparam int PDEC_W  = 10;
    localparam int SELI_W  = 7;
    localparam int SELP_W  = 5;

    // datapath widths
    localparam int PROD_W  = 32;             // m * fin, m <= 60
    localparam int TN_W    = TGT_W + N_W;    // target * n
    localparam int DIFF_W  = TN_W + 1;       // signed m*fin - target*n
    localparam int MLFSR_W = 15;
    localparam int NLFSR_W = 8;
    localparam int MCNT_W  = 16;
    localparam int NCNT_W  = 8;

    // APB port
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register word indexes
    localparam logic [1:0] REG_INPUT_FREQ = 2'd0;
    localparam logic [1:0] REG_VCO_MIN    = 2'd1;
    localparam logic [1:0] REG_VCO_MAX    = 2'd2;

    // register reset values
    localparam logic [FIN_W-1:0] INPUT_FREQ_RST = 26'd12000000;
    localparam logic [VCO_W-1:0] VCO_MIN_RST    = 32'd60000000;
    localparam logic [VCO_W-1:0] VCO_MAX_RST    = 32'd500000000;

    // encoder constants
    localparam logic [MDEC_W-1:0]  MDEC_M1       = 17'h18003;
    localparam logic [MDEC_W-1:0]  MDEC_M2       = 17'h10003;
    localparam logic [MLFSR_W-1:0] MDEC_SEED     = 15'h4000;
    localparam logic [MCNT_W-1:0]  MDEC_CNT_BASE = 16'h8001;  // steps = 0x8000 - m + 1
    localparam logic [NDEC_W-1:0]  NDEC_N1       = 10'h302;
    localparam logic [NDEC_W-1:0]  NDEC_N2       = 10'h202;
    localparam logic [NLFSR_W-1:0] NDEC_SEED     = 8'h80;
    localparam logic [NCNT_W:0]    NDEC_CNT_BASE = 9'h101;    // steps = 0x100 - n + 1
    localparam logic [PDEC_W-1:0]  PDEC_P1       = 10'h062;
    localparam logic [M_W-1:0]     SELI_MASK     = 6'h3c;
    localparam logic [SELI_W-1:0]  SELI_OFFSET   = 7'd4;
    localparam logic [SELP_W-1:0]  SELP_OFFSET   = 5'd1;
    localparam logic [M_W-1:0]     M_ONE         = 6'd1;
    localparam logic [M_W-1:0]     M_TWO         = 6'd2;
    localparam logic [N_W-1:0]     N_ONE         = 8'd1;
    localparam logic [N_W-1:0]     N_TWO         = 8'd2;
    localparam int                 MSTEP_FAST    = 8;          // LFSR steps per fast cycle

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_CHK,
        ST_ENC_M,
        ST_ENC_N,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [FIN_W-1:0] input_freq_hz;
        logic [VCO_W-1:0] vco_min_hz;
        logic [VCO_W-1:0] vco_max_hz;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic init;      // capture request, restart search at m=1 n=1
        logic sub;       // form m*fin - target*n
        logic chk;       // test pair; load encoders on hit, else advance
        logic m_step;    // step MDEC LFSR
        logic n_step;    // step NDEC LFSR
        logic out_load;  // load result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic last_pair;
        logic m_enc_done;
        logic n_enc_done;
    } dp_sts_t;

    // one MDEC LFSR step
    function automatic logic [MLFSR_W-1:0] mdec_step(input logic [MLFSR_W-1:0] x);
        return {x[0] ^ x[1], x[MLFSR_W-1:1]};
    endfunction

    // MSTEP_FAST MDEC LFSR steps
    function automatic logic [MLFSR_W-1:0] mdec_step_fast(input logic [MLFSR_W-1:0] x);
        logic [MLFSR_W-1:0] y;
        y = x;
        for (int i = 0; i < MSTEP_FAST; i++) begin
            y = mdec_step(y);
        end
        return y;
    endfunction

    // one NDEC LFSR step
    function automatic logic [NLFSR_W-1:0] ndec_step(input logic [NLFSR_W-1:0] x);
        return {x[0] ^ x[2] ^ x[3] ^ x[4], x[NLFSR_W-1:1]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pdse_regs.sv @@
`default_nettype none

module pdse_regs
    import pdse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [FIN_W-1:0] input_freq_reg;
    logic [VCO_W-1:0] vco_min_reg;
    logic [VCO_W-1:0] vco_max_reg;
    logic             wr_en;
    logic [1:0]       word_idx;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign word_idx = paddr[ADDR_W-1:2];

    // register writes, unknown words ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_freq_reg <= INPUT_FREQ_RST;
            vco_min_reg    <= VCO_MIN_RST;
            vco_max_reg    <= VCO_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (word_idx)
                REG_INPUT_FREQ: input_freq_reg <= pwdata[FIN_W-1:0];
                REG_VCO_MIN:    vco_min_reg    <= pwdata[VCO_W-1:0];
                REG_VCO_MAX:    vco_max_reg    <= pwdata[VCO_W-1:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (word_idx)
            REG_INPUT_FREQ: prdata = {{(DATA_W-FIN_W){1'b0}}, input_freq_reg};
            REG_VCO_MIN:    prdata = vco_min_reg;
            REG_VCO_MAX:    prdata = vco_max_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg.input_freq_hz = input_freq_reg;
    assign cfg.vco_min_hz    = vco_min_reg;
    assign cfg.vco_max_hz    = vco_max_reg;

endmodule

`default_nettype wire

@@ rtl/core/pdse_ctrl.sv @@
`default_nettype none

module pdse_ctrl
    import pdse_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_SUB;
            ST_SUB:   state_next = ST_CHK;
            ST_CHK:
            begin
                priority if (sts.hit)       state_next = ST_ENC_M;
                else if (sts.last_pair)     state_next = ST_OUT;
                else                        state_next = ST_SUB;
            end
            ST_ENC_M: if (sts.m_enc_done) state_next = ST_ENC_N;
            ST_ENC_N: if (sts.n_enc_done) state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath commands and handshakes
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.init = in_valid;
            end
            ST_SUB:   cmd.sub      = 1'b1;
            ST_CHK:   cmd.chk      = 1'b1;
            ST_ENC_M: cmd.m_step   = 1'b1;
            ST_ENC_N: cmd.n_step   = 1'b1;
            ST_OUT:   cmd.out_load = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    // output slot: filled on load, freed on transfer
    always_comb
    begin
        priority if (cmd.out_load) out_valid_next = 1'b1;
        else if (out_ready)        out_valid_next = 1'b0;
        else                       out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/pdse_dp.sv @@
`default_nettype none

module pdse_dp
    import pdse_pkg::*;
(
    input  wire logic             clk,
    input  wire cfg_t             cfg,
    input  wire dp_cmd_t          cmd,
    output dp_sts_t               sts,
    input  wire logic [TGT_W-1:0] target_freq_hz,
    output logic                  found,
    output logic      [M_W-1:0]   mult_m,
    output logic      [N_W-1:0]   prediv_n,
    output logic      [TGT_W-1:0] out_freq_hz,
    output logic      [MDEC_W-1:0] mdec_code,
    output logic      [NDEC_W-1:0] ndec_code,
    output logic      [PDEC_W-1:0] pdec_code,
    output logic      [SELI_W-1:0] sel_i,
    output logic      [SELP_W-1:0] sel_p
);

    // search state
    logic [TGT_W-1:0]   tgt_reg;
    logic [PROD_W-1:0]  a_reg;      // m * fin
    logic [TN_W-1:0]    b_reg;      // target * n
    logic [DIFF_W-1:0]  diff_reg;
    logic [M_W-1:0]     m_reg;
    logic [N_W-1:0]     n_reg;
    logic               found_reg;
    logic               lo_ok_reg;  // fcco = 2*target inside window
    logic               hi_ok_reg;  // fcco = 2*target+1 inside window

    // encoder state
    logic [MLFSR_W-1:0] mlfsr_reg;
    logic [MLFSR_W-1:0] mlfsr_next;
    logic [MCNT_W-1:0]  mcnt_reg;
    logic [MCNT_W-1:0]  mcnt_next;
    logic [NLFSR_W-1:0] nlfsr_reg;
    logic [NCNT_W-1:0]  ncnt_reg;

    logic [VCO_W-1:0]   fcco_lo;
    logic [VCO_W-1:0]   fcco_hi;
    logic               in_rng;
    logic               upper_half;
    logic               n_wrap;
    logic [MCNT_W-1:0]  mcnt_init;
    logic [NCNT_W:0]    ncnt_full;
    logic [NCNT_W-1:0]  ncnt_init;
    logic [MDEC_W-1:0]  mdec_val;
    logic [NDEC_W-1:0]  ndec_val;

    // the two possible fcco values for this request
    assign fcco_lo = {{(VCO_W-TGT_W-1){1'b0}}, target_freq_hz, 1'b0};
    assign fcco_hi = {{(VCO_W-TGT_W-1){1'b0}}, target_freq_hz, 1'b1};

    // floor(m*fin/n) == target  <=>  0 <= diff < n; fcco odd when 2*diff >= n
    assign in_rng     = !diff_reg[DIFF_W-1] && (diff_reg[DIFF_W-2:N_W] == '0)
                        && (diff_reg[N_W-1:0] < n_reg);
    assign upper_half = {diff_reg[N_W-1:0], 1'b0} >= {1'b0, n_reg};

    assign sts.hit        = in_rng && (upper_half ? hi_ok_reg : lo_ok_reg);
    assign sts.last_pair  = (m_reg == M_W'(MAX_MULT)) && (n_reg == N_W'(MAX_PREDIV));
    assign sts.m_enc_done = (mcnt_reg == '0);
    assign sts.n_enc_done = (ncnt_reg == '0);

    assign n_wrap = (n_reg == N_W'(MAX_PREDIV));

    // LFSR step counts, zero for the fixed codes
    assign mcnt_init = (m_reg == M_ONE || m_reg == M_TWO) ? '0
                       : MDEC_CNT_BASE - {{(MCNT_W-M_W){1'b0}}, m_reg};
    assign ncnt_full = NDEC_CNT_BASE - {1'b0, n_reg};
    assign ncnt_init = (n_reg == N_ONE || n_reg == N_TWO) ? '0 : ncnt_full[NCNT_W-1:0];

    // MDEC stepping: eight steps a cycle while at least eight remain
    always_comb
    begin
        mlfsr_next = mlfsr_reg;
        mcnt_next  = mcnt_reg;
        if (mcnt_reg[MCNT_W-1:3] != '0)
        begin
            mlfsr_next = mdec_step_fast(mlfsr_reg);
            mcnt_next  = mcnt_reg - MCNT_W'(MSTEP_FAST);
        end
        else if (mcnt_reg != '0)
        begin
            mlfsr_next = mdec_step(mlfsr_reg);
            mcnt_next  = mcnt_reg - 1'b1;
        end
    end

    // search datapath
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            tgt_reg   <= target_freq_hz;
            a_reg     <= {{(PROD_W-FIN_W){1'b0}}, cfg.input_freq_hz};
            b_reg     <= {{(TN_W-TGT_W){1'b0}}, target_freq_hz};
            m_reg     <= M_ONE;
            n_reg     <= N_ONE;
            found_reg <= 1'b0;
            lo_ok_reg <= (fcco_lo >= cfg.vco_min_hz) && (fcco_lo <= cfg.vco_max_hz);
            hi_ok_reg <= (fcco_hi >= cfg.vco_min_hz) && (fcco_hi <= cfg.vco_max_hz);
        end
        if (cmd.sub)
        begin
            diff_reg <= {{(DIFF_W-PROD_W){1'b0}}, a_reg} - {1'b0, b_reg};
        end
        if (cmd.chk)
        begin
            if (sts.hit)
            begin
                found_reg <= 1'b1;
            end
            else if (!sts.last_pair)
            begin
                if (n_wrap)
                begin
                    n_reg <= N_ONE;
                    b_reg <= {{(TN_W-TGT_W){1'b0}}, tgt_reg};
                    m_reg <= m_reg + 1'b1;
                    a_reg <= a_reg + {{(PROD_W-FIN_W){1'b0}}, cfg.input_freq_hz};
                end
                else
                begin
                    n_reg <= n_reg + 1'b1;
                    b_reg <= b_reg + {{(TN_W-TGT_W){1'b0}}, tgt_reg};
                end
            end
        end
    end

    // encoders
    always_ff @(posedge clk)
    begin
        if (cmd.chk && sts.hit)
        begin
            mlfsr_reg <= MDEC_SEED;
            mcnt_reg  <= mcnt_init;
            nlfsr_reg <= NDEC_SEED;
            ncnt_reg  <= ncnt_init;
        end
        else
        begin
            if (cmd.m_step)
            begin
                mlfsr_reg <= mlfsr_next;
                mcnt_reg  <= mcnt_next;
            end
            if (cmd.n_step && (ncnt_reg != '0))
            begin
                nlfsr_reg <= ndec_step(nlfsr_reg);
                ncnt_reg  <= ncnt_reg - 1'b1;
            end
        end
    end

    // final codes
    always_comb
    begin
        priority if (m_reg == M_ONE) mdec_val = MDEC_M1;
        else if (m_reg == M_TWO)     mdec_val = MDEC_M2;
        else                         mdec_val = {{(MDEC_W-MLFSR_W){1'b0}}, mlfsr_reg};
        priority if (n_reg == N_ONE) ndec_val = NDEC_N1;
        else if (n_reg == N_TWO)     ndec_val = NDEC_N2;
        else                         ndec_val = {{(NDEC_W-NLFSR_W){1'b0}}, nlfsr_reg};
    end

    // result register, all zero on no match
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found <= found_reg;
            if (found_reg)
            begin
                mult_m      <= m_reg;
                prediv_n    <= n_reg;
                out_freq_hz <= tgt_reg;
                mdec_code   <= mdec_val;
                ndec_code   <= ndec_val;
                pdec_code   <= PDEC_P1;
                sel_i       <= {1'b0, m_reg & SELI_MASK} + SELI_OFFSET;
                sel_p       <= m_reg[M_W-1:1] + SELP_OFFSET;
            end
            else
            begin
                mult_m      <= '0;
                prediv_n    <= '0;
                out_freq_hz <= '0;
                mdec_code   <= '0;
                ndec_code   <= '0;
                pdec_code   <= '0;
                sel_i       <= '0;
                sel_p       <= '0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pll_divider_search_encode_core.sv @@
// PLL divider search and code encoder.
// Registers (APB, pready always high): input_freq_hz at 0x0, vco_min_hz at
// 0x4, vco_max_hz at 0x8; write them only while no request is in flight.
// Request channel (in_valid/in_ready): one target_freq_hz per transfer. The
// block takes a new request only when the previous one has finished its
// search and encoding.
// Search: M from 1 to 60 outer, N from 1 to 255 inner, each pair tried in a
// subtract state and then a test state.
// Encoding after a match: (32769 - M) LFSR steps for MDEC at eight a cycle
// while eight remain, then single ones; then (257 - N) single steps for NDEC;
// M or N of 1 or 2 skip their steps.
// Result channel (out_valid/out_ready): a result register holds the last
// result; a stalled receiver keeps it, and a new request may be taken but
// its result waits until the register is freed.
// Reset: registers return to 12 MHz / 60 MHz / 500 MHz, no result pending.

`default_nettype none

module pll_divider_search_encode_core
    import pdse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [TGT_W-1:0]  target_freq_hz,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   found,
    output logic      [M_W-1:0]    mult_m,
    output logic      [N_W-1:0]    prediv_n,
    output logic      [TGT_W-1:0]  out_freq_hz,
    output logic      [MDEC_W-1:0] mdec_code,
    output logic      [NDEC_W-1:0] ndec_code,
    output logic      [PDEC_W-1:0] pdec_code,
    output logic      [SELI_W-1:0] sel_i,
    output logic      [SELP_W-1:0] sel_p
);

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // configuration registers
    pdse_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    pdse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // search and encode datapath
    pdse_dp u_dp (
        .clk            (clk),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .target_freq_hz (target_freq_hz),
        .found          (found),
        .mult_m         (mult_m),
        .prediv_n       (prediv_n),
        .out_freq_hz    (out_freq_hz),
        .mdec_code      (mdec_code),
        .ndec_code      (ndec_code),
        .pdec_code      (pdec_code),
        .sel_i          (sel_i),
        .sel_p          (sel_p)
    );

endmodule

`default_nettype wire

@@ rtl/core/pdse_checker.sv @@
`default_nettype none

`include "pll_divider_search_encode_core_macros.svh"

module pdse_checker
    import pdse_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              found,
    input wire logic [M_W-1:0]    mult_m,
    input wire logic [N_W-1:0]    prediv_n,
    input wire logic [TGT_W-1:0]  out_freq_hz,
    input wire logic [MDEC_W-1:0] mdec_code,
    input wire logic [NDEC_W-1:0] ndec_code,
    input wire logic [PDEC_W-1:0] pdec_code,
    input wire logic [SELI_W-1:0] sel_i,
    input wire logic [SELP_W-1:0] sel_p
);

    // a request transfer always starts a search and leaves the block busy
    `PDSE_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")

    // a stalled result holds
    `PDSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(mult_m) && $stable(prediv_n) && $stable(mdec_code) && $stable(ndec_code), "stalled result changed")

    // no match gives an all-zero result
    `PDSE_ASSERT_SAME(a_miss_zero, out_valid && !found, mult_m == '0 && prediv_n == '0 && out_freq_hz == '0 && mdec_code == '0 && ndec_code == '0 && pdec_code == '0 && sel_i == '0 && sel_p == '0, "miss result not zero")

    // a match carries legal dividers and a consistent sel_p
    `PDSE_ASSERT_SAME(a_hit_fields, out_valid && found, mult_m != '0 && mult_m <= M_W'(MAX_MULT) && prediv_n != '0 && pdec_code == PDEC_P1 && sel_p == mult_m[M_W-1:1] + SELP_OFFSET, "bad match fields")

endmodule

bind pll_divider_search_encode_core pdse_checker u_pdse_checker (.*);

`default_nettype wire
